// ===== sv/sidechain_ducking_envelope_core_macros.svh =====
// Assertion macros shared by the ducking envelope RTL.
`ifndef SIDECHAIN_DUCKING_ENVELOPE_CORE_MACROS_SVH
`define SIDECHAIN_DUCKING_ENVELOPE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SDE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sde_pkg.sv =====
// Shared types and constants for the sidechain ducking envelope core.
package sde_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ALPHA_ATTACK   = 3'd0;
    localparam logic [2:0] REG_ALPHA_RELEASE  = 3'd1;
    localparam logic [2:0] REG_MUSIC_DUCK     = 3'd2;
    localparam logic [2:0] REG_SFX_DUCK       = 3'd3;
    localparam logic [2:0] REG_AMBIENT_DUCK   = 3'd4;
    localparam logic [2:0] REG_MUSIC_PRIORITY = 3'd5;
    localparam logic [2:0] REG_RESTORE_RATE   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [15:0]        RST_ALPHA_ATTACK   = 16'd1024;
    localparam logic [15:0]        RST_ALPHA_RELEASE  = 16'd256;
    localparam logic signed [15:0] RST_MUSIC_DUCK     = -16'sd3072;
    localparam logic signed [15:0] RST_SFX_DUCK       = -16'sd1536;
    localparam logic signed [15:0] RST_AMBIENT_DUCK   = -16'sd1536;
    localparam logic [16:0]        RST_MUSIC_PRIORITY = 17'd65536;
    localparam logic [23:0]        RST_RESTORE_RATE   = 24'd16777;

    // Envelope full scale (1.0 in Q1.15) and carve threshold (0.03)
    localparam logic [15:0] ENV_ONE      = 16'd32768;
    localparam logic [15:0] CARVE_THRESH = 16'd983;

    // Default structural settings
    localparam int BLEND_TABLE_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF      = 2;

    typedef struct packed {
        logic [15:0]        alpha_attack;
        logic [15:0]        alpha_release;
        logic signed [15:0] music_duck;
        logic signed [15:0] sfx_duck;
        logic signed [15:0] ambient_duck;
        logic [16:0]        music_priority;
        logic [23:0]        restore_rate;
    } t_cfg;

    // One tick after the envelope update, waiting for the gain engine
    typedef struct packed {
        logic [15:0] env;
        logic [31:0] silent;
    } t_item;

endpackage

// ===== sv/sidechain_ducking_envelope_core.sv =====
// Top level of the sidechain ducking envelope core.
// Input channel: i_valid / o_stall with i_voice_active, one transaction per
// control tick. Output channel: o_valid / i_stall carrying the envelope, the
// music, sfx and ambient duck gains (Q7.8 dB), the carve flag and the music
// restore gain. Every input transaction produces exactly one output.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; write
// only while the core is idle. Unknown indexes are ignored.
// Sequencing: the front end steps the envelope in the accept cycle and
// queues the tick; the gain engine takes a load step, 16 steps of a
// multiply phase and a fold phase (15 multiplies on one shared 32x32
// multiplier plus a table index step) and a finish step, and takes a new
// tick only once the last one has left its finish step.
// Input is stalled only while the tick queue is full; up to QUEUE_DEPTH
// queued ticks, one tick in the engine and one result can be in flight.
// Reset (synchronous, active low) loads the register defaults, clears the
// envelope and silence count, empties the queue and drops output valid.
// A stalled result holds its payload; the engine waits in its finish step.
module sidechain_ducking_envelope_core #(
    parameter int BLEND_TABLE_BITS = sde_pkg::BLEND_TABLE_BITS_DEF,
    parameter int QUEUE_DEPTH      = sde_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sde_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sde_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_voice_active,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [15:0]                    o_envelope,
    output logic signed [15:0]             o_music_gain,
    output logic signed [15:0]             o_sfx_gain,
    output logic signed [15:0]             o_ambient_gain,
    output logic                           o_carve_on,
    output logic signed [15:0]             o_restore_gain
);
    import sde_pkg::*;

    t_cfg  r_cfg;
    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_attack   <= RST_ALPHA_ATTACK;
            r_cfg.alpha_release  <= RST_ALPHA_RELEASE;
            r_cfg.music_duck     <= RST_MUSIC_DUCK;
            r_cfg.sfx_duck       <= RST_SFX_DUCK;
            r_cfg.ambient_duck   <= RST_AMBIENT_DUCK;
            r_cfg.music_priority <= RST_MUSIC_PRIORITY;
            r_cfg.restore_rate   <= RST_RESTORE_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALPHA_ATTACK:   r_cfg.alpha_attack   <= i_cfg_data[15:0];
                REG_ALPHA_RELEASE:  r_cfg.alpha_release  <= i_cfg_data[15:0];
                REG_MUSIC_DUCK:     r_cfg.music_duck     <= i_cfg_data[15:0];
                REG_SFX_DUCK:       r_cfg.sfx_duck       <= i_cfg_data[15:0];
                REG_AMBIENT_DUCK:   r_cfg.ambient_duck   <= i_cfg_data[15:0];
                REG_MUSIC_PRIORITY: r_cfg.music_priority <= i_cfg_data[16:0];
                REG_RESTORE_RATE:   r_cfg.restore_rate   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    sde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .i_voice_active (i_voice_active),
        .o_stall        (o_stall),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    sde_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    sde_back #(
        .BLEND_TABLE_BITS (BLEND_TABLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (q_valid),
        .i_item         (pop_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_envelope     (o_envelope),
        .o_music_gain   (o_music_gain),
        .o_sfx_gain     (o_sfx_gain),
        .o_ambient_gain (o_ambient_gain),
        .o_carve_on     (o_carve_on),
        .o_restore_gain (o_restore_gain)
    );

endmodule

// ===== sv/sde_fifo.sv =====
// Short register queue between the envelope front end and the gain engine.
module sde_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sde_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sde_pkg::t_item o_item
);
    import sde_pkg::*;
    `include "sidechain_ducking_envelope_core_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SDE_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `SDE_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ===== sv/sde_front.sv =====
// Front end: accepts ticks, steps the envelope and the silence count.
module sde_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sde_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  logic           i_voice_active,
    output logic           o_stall,
    input  logic           i_full,
    output logic           o_push,
    output sde_pkg::t_item o_item
);
    import sde_pkg::*;
    `include "sidechain_ducking_envelope_core_macros.svh"

    logic [15:0] r_env;
    logic [31:0] r_sil;
    logic [15:0] n_env;
    logic [31:0] n_sil;

    logic        accept;
    logic        rise;
    logic [15:0] alpha;
    logic [15:0] gap;
    logic [31:0] prod;
    logic [32:0] rnd;
    logic [16:0] step;
    logic [16:0] env_sum;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign o_item  = '{env: n_env, silent: n_sil};

    // One-pole step toward the target, attack on the way up
    always_comb begin
        rise    = i_voice_active && (r_env < ENV_ONE);
        alpha   = rise ? i_cfg.alpha_attack : i_cfg.alpha_release;
        gap     = rise ? (ENV_ONE - r_env) : (i_voice_active ? 16'd0 : r_env);
        prod    = alpha * gap;
        rnd     = {1'b0, prod} + 33'd32768;
        step    = rnd[32:16];
        env_sum = rise ? ({1'b0, r_env} + step) : ({1'b0, r_env} - step);
        n_env   = env_sum[15:0];
    end

    // Clear on voice, otherwise count up and hold at the top
    always_comb begin
        if (i_voice_active) begin
            n_sil = '0;
        end else if (r_sil != '1) begin
            n_sil = r_sil + 1'b1;
        end else begin
            n_sil = r_sil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
            r_sil <= '0;
        end else if (accept) begin
            r_env <= n_env;
            r_sil <= n_sil;
        end
    end

    `SDE_ASSERT_IMP(a_env_range, i_clk, i_rst_n, 1'b1, r_env <= ENV_ONE, "envelope above full scale")

endmodule

// ===== sv/sde_back.sv =====
// Gain engine: shared multiplier sequencer for duck gains and restore curve.
module sde_back #(
    parameter int BLEND_TABLE_BITS = sde_pkg::BLEND_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sde_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  sde_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_envelope,
    output logic signed [15:0] o_music_gain,
    output logic signed [15:0] o_sfx_gain,
    output logic signed [15:0] o_ambient_gain,
    output logic               o_carve_on,
    output logic signed [15:0] o_restore_gain
);
    import sde_pkg::*;
    `include "sidechain_ducking_envelope_core_macros.svh"

    localparam int B = BLEND_TABLE_BITS;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Multiply operations, in issue order
    localparam logic [3:0] OP_DP     = 4'd0;
    localparam logic [3:0] OP_MUS_LO = 4'd1;
    localparam logic [3:0] OP_MUS_HI = 4'd2;
    localparam logic [3:0] OP_SFX    = 4'd3;
    localparam logic [3:0] OP_AMB    = 4'd4;
    localparam logic [3:0] OP_U_LO   = 4'd5;
    localparam logic [3:0] OP_U_HI   = 4'd6;
    localparam logic [3:0] OP_IDX    = 4'd7;
    localparam logic [3:0] OP_X2     = 4'd8;
    localparam logic [3:0] OP_P7     = 4'd9;
    localparam logic [3:0] OP_P5     = 4'd10;
    localparam logic [3:0] OP_P3     = 4'd11;
    localparam logic [3:0] OP_SIN    = 4'd12;
    localparam logic [3:0] OP_SQR    = 4'd13;
    localparam logic [3:0] OP_RES_LO = 4'd14;
    localparam logic [3:0] OP_RES_HI = 4'd15;

    // Q30 sine polynomial coefficients
    localparam logic [30:0] SIN_C1  = 31'd1686629713;
    localparam logic [30:0] SIN_C3  = 31'd693598675;
    localparam logic [30:0] SIN_C5  = 31'd85569306;
    localparam logic [30:0] SIN_C7  = 31'd5026993;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [16:0] BLEND_ONE = 17'd65536;

    // Round to nearest, half away from zero, then saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [49:0] p,
                                                     input int unsigned sh);
        logic signed [50:0] pe;
        logic [50:0]        mag;
        logic [50:0]        m;
        logic signed [15:0] res;
        pe  = 51'(p);
        mag = p[49] ? -pe : pe;
        m   = (mag + (51'd1 << (sh - 1))) >> sh;
        if (p[49]) begin
            res = (m > 51'd32768) ? 16'sh8000 : 16'(-m);
        end else begin
            res = (m > 51'd32767) ? 16'sh7fff : 16'(m);
        end
        return res;
    endfunction

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [3:0]         r_op;
    logic               r_ph;

    logic [15:0]        r_env;
    logic [31:0]        r_sil;
    logic signed [63:0] r_prod;
    logic signed [33:0] r_dp;
    logic signed [49:0] r_acc_m;
    logic signed [31:0] r_sfx;
    logic signed [31:0] r_amb;
    logic [55:0]        r_u;
    logic [30:0]        r_x;
    logic [30:0]        r_x2;
    logic [30:0]        r_p;
    logic [30:0]        r_s;
    logic [16:0]        r_w;
    logic signed [49:0] r_acc_r;

    logic               r_out_valid;
    logic [15:0]        r_out_env;
    logic signed [15:0] r_out_music;
    logic signed [15:0] r_out_sfx;
    logic signed [15:0] r_out_amb;
    logic               r_out_carve;
    logic signed [15:0] r_out_restore;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [16:0] dp_hi;
    logic [16:0]        dp_lo;
    logic               out_free;
    logic               u_sat;
    logic [B:0]         idx;
    logic [30:0]        x_next;
    logic [31:0]        s_full;
    logic [61:0]        sq_rnd;
    logic [17:0]        blend_raw;
    logic [16:0]        blend;

    assign dp_hi    = r_dp[33:17];
    assign dp_lo    = r_dp[16:0];
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_valid;

    // Table index from restore progress, saturated at the end of the window
    assign u_sat  = |r_u[55:24];
    assign idx    = u_sat ? {1'b1, {B{1'b0}}} : {1'b0, r_u[23:24-B]};
    assign x_next = {idx, {(30 - B){1'b0}}};

    // Sine clamp and squared blend from the product
    assign s_full    = r_prod[61:30];
    assign sq_rnd    = r_prod[61:0] + (62'd1 << 43);
    assign blend_raw = sq_rnd[61:44];
    assign blend     = (blend_raw > 18'(BLEND_ONE)) ? BLEND_ONE : blend_raw[16:0];

    // Select multiplier operands for the current operation
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_DP: begin
                mul_a = 32'(i_cfg.music_duck);
                mul_b = 32'(i_cfg.music_priority);
            end
            OP_MUS_LO: begin
                mul_a = 32'(r_env);
                mul_b = 32'(dp_lo);
            end
            OP_MUS_HI: begin
                mul_a = 32'(r_env);
                mul_b = 32'(dp_hi);
            end
            OP_SFX: begin
                mul_a = 32'(r_env);
                mul_b = 32'(i_cfg.sfx_duck);
            end
            OP_AMB: begin
                mul_a = 32'(r_env);
                mul_b = 32'(i_cfg.ambient_duck);
            end
            OP_U_LO: begin
                mul_a = 32'(r_sil[15:0]);
                mul_b = 32'(i_cfg.restore_rate);
            end
            OP_U_HI: begin
                mul_a = 32'(r_sil[31:16]);
                mul_b = 32'(i_cfg.restore_rate);
            end
            OP_X2: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_x);
            end
            OP_P7: begin
                mul_a = 32'(r_x2);
                mul_b = 32'(SIN_C7);
            end
            OP_P5, OP_P3: begin
                mul_a = 32'(r_x2);
                mul_b = 32'(r_p);
            end
            OP_SIN: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_p);
            end
            OP_SQR: begin
                mul_a = 32'(r_s);
                mul_b = 32'(r_s);
            end
            OP_RES_LO: begin
                mul_a = 32'(dp_lo);
                mul_b = 32'(r_w);
            end
            OP_RES_HI: begin
                mul_a = 32'(dp_hi);
                mul_b = 32'(r_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_ph && (r_op == OP_RES_HI)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control: state, operation and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_DP;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_op <= OP_DP;
                r_ph <= 1'b0;
            end else if (r_state == ST_RUN) begin
                r_ph <= !r_ph;
                if (r_ph && (r_op != OP_RES_HI)) begin
                    r_op <= r_op + 1'b1;
                end
            end
        end
    end

    // Datapath: load the tick, multiply on phase 0, fold the product on phase 1
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_env <= i_item.env;
            r_sil <= i_item.silent;
        end
        if ((r_state == ST_RUN) && !r_ph) begin
            r_prod <= mul_a * mul_b;
        end
        if ((r_state == ST_RUN) && r_ph) begin
            case (r_op)
                OP_DP:     r_dp    <= r_prod[33:0];
                OP_MUS_LO: r_acc_m <= r_prod[49:0];
                OP_MUS_HI: r_acc_m <= r_acc_m + {r_prod[32:0], 17'd0};
                OP_SFX:    r_sfx   <= r_prod[31:0];
                OP_AMB:    r_amb   <= r_prod[31:0];
                OP_U_LO:   r_u     <= {16'd0, r_prod[39:0]};
                OP_U_HI:   r_u     <= r_u + {r_prod[39:0], 16'd0};
                OP_IDX:    r_x     <= x_next;
                OP_X2:     r_x2    <= r_prod[60:30];
                OP_P7:     r_p     <= SIN_C5 - r_prod[60:30];
                OP_P5:     r_p     <= 31'(32'(SIN_C3) - r_prod[61:30]);
                OP_P3:     r_p     <= 31'(32'(SIN_C1) - r_prod[61:30]);
                OP_SIN:    r_s     <= (s_full > 32'(Q30_ONE)) ? Q30_ONE : s_full[30:0];
                OP_SQR:    r_w     <= BLEND_ONE - blend;
                OP_RES_LO: r_acc_r <= r_prod[49:0];
                OP_RES_HI: r_acc_r <= r_acc_r + {r_prod[32:0], 17'd0};
                default: ;
            endcase
        end
    end

    // Result register: load when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_env     <= r_env;
            r_out_music   <= round_sat(r_acc_m, 31);
            r_out_sfx     <= round_sat(50'(r_sfx), 15);
            r_out_amb     <= round_sat(50'(r_amb), 15);
            r_out_carve   <= (r_env > CARVE_THRESH);
            r_out_restore <= round_sat(r_acc_r, 32);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_envelope     = r_out_env;
    assign o_music_gain   = r_out_music;
    assign o_sfx_gain     = r_out_sfx;
    assign o_ambient_gain = r_out_amb;
    assign o_carve_on     = r_out_carve;
    assign o_restore_gain = r_out_restore;

    `SDE_ASSERT_NXT(a_fin_hold, i_clk, i_rst_n, (r_state == ST_FIN) && !out_free, r_state == ST_FIN, "finished tick left while result blocked")
    `SDE_ASSERT_IMP(a_valid_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_FIN, "result raised outside finish")

endmodule
